// File: rtl/core/clb_pkg.sv
// Shared types, codes and constants of the character-LCD bus sequencer.
`default_nettype none
package clb_pkg;

  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;
  localparam int COL_W      = 6;
  localparam int CNT_W      = 3;
  localparam int MAX_BYTES  = 4;
  localparam int BSEL_W     = $clog2(MAX_BYTES);
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_COMMAND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DATA    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CURSOR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INIT    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BUS_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH    = 2'd3;

  localparam logic        RST_BUS_MODE      = 1'b1;
  localparam logic [21:0] RST_STARTUP_TICKS = 22'd2000000;
  localparam logic [5:0]  RST_ROW_LENGTH    = 6'd16;

  localparam logic [COL_W-1:0] COL_MAX = 6'd63;

  localparam logic [7:0] INS_FUNC_8BIT  = 8'b0011_1000;
  localparam logic [7:0] INS_DISP_ON    = 8'b0000_1100;
  localparam logic [7:0] INS_CLEAR      = 8'b0000_0001;
  localparam logic [7:0] INS_FUNC_4BIT  = 8'b0010_0010;
  localparam logic [7:0] INS_ROW0       = 8'b1000_0000;
  localparam logic [7:0] INS_ROW1       = 8'b1100_0000;
  localparam logic [7:0] INS_ENTRY_LAST = 8'b0001_1111;

  typedef struct packed {
    logic                            mode;
    logic [CNT_W-1:0]                count;
    logic [MAX_BYTES-1:0][7:0]       bytes;
    logic [MAX_BYTES-1:0]            rs;
    logic                            wait_first;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_rd_t;

endpackage
`default_nettype wire

// File: rtl/core/clb_in_if.sv
// Request channel carrying one sequencer item.
`default_nettype none
interface clb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] byte_value;
  logic [5:0] column;
  logic       row;
  logic       text_start;

  modport source (output valid, cmd, byte_value, column, row, text_start, input ready);
  modport sink (input valid, cmd, byte_value, column, row, text_start, output ready);
endinterface
`default_nettype wire

// File: rtl/core/clb_out_if.sv
// Request channel carrying one bus transfer.
`default_nettype none
interface clb_out_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [7:0] bus_value;
  logic       startup_wait;
  logic       last;

  modport source (output valid, reg_select, bus_value, startup_wait, last, input ready);
  modport sink (input valid, reg_select, bus_value, startup_wait, last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/char_lcd_bus_sequencer_core.sv
// Top level of the character-LCD bus sequencer.
// The first transfer of an item is registered at the output after the item has been written into the job queue.
// The back end issues one transfer per cycle while the output is not stalled; an item expands into 1 to 7 transfers.
// The job queue holds two items, and the input is ready whenever the queue is not full.
// Reset empties the queue and output, clears the text counter and loads register defaults.
`default_nettype none
module char_lcd_bus_sequencer_core import clb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  clb_in_if.sink                     item,
  clb_out_if.source                  xfer
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  clb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  clb_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .pop  (q_pop),
    .full (q_full),
    .q_rd (q_rd)
  );

  clb_back u_back (
    .clk  (clk),
    .rst  (rst),
    .q_rd (q_rd),
    .pop  (q_pop),
    .xfer (xfer)
  );

endmodule
`default_nettype wire

// File: rtl/core/clb_front.sv
// Front end: configuration registers, text counter and item classification.
`default_nettype none
module clb_front import clb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  clb_in_if.sink                     item,
  input  wire logic                  q_full,
  output q_wr_t                      q_wr
);

  logic                  bus_mode;
  logic [CFG_DATA_W-1:0] startup_ticks;
  logic [COL_W-1:0]      row_length;
  logic [COL_W-1:0]      text_column;
  logic [COL_W-1:0]      text_column_next;
  logic [COL_W-1:0]      col_base;
  logic [COL_W-1:0]      col_inc;
  logic                  do_inc;
  logic                  wrap;
  logic                  known;
  logic                  accept;
  job_t                  job;

  // The enable pulse width only matters to the pin driver downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_mode      <= RST_BUS_MODE;
      startup_ticks <= RST_STARTUP_TICKS;
      row_length    <= RST_ROW_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUS_MODE:      bus_mode      <= cfg_data[0];
        REG_PULSE_TICKS:   ;
        REG_STARTUP_TICKS: startup_ticks <= cfg_data;
        REG_ROW_LENGTH:    row_length    <= cfg_data[COL_W-1:0];
        default:           ;
      endcase
    end
  end

  assign item.ready = !q_full;
  assign accept     = item.valid && !q_full;

  always_comb begin
    col_base         = item.text_start ? '0 : text_column;
    do_inc           = col_base != COL_MAX;
    col_inc          = col_base + 6'd1;
    wrap             = do_inc && (col_inc == row_length);
    text_column_next = do_inc ? col_inc : col_base;

    known          = 1'b1;
    job.mode       = bus_mode;
    job.count      = '0;
    job.bytes      = '0;
    job.rs         = '0;
    job.wait_first = 1'b0;
    case (item.cmd)
      CMD_COMMAND: begin
        job.bytes[0] = item.byte_value;
        job.count    = bus_mode ? 3'd2 : 3'd1;
      end
      CMD_DATA: begin
        job.bytes[0] = item.byte_value;
        job.rs[0]    = 1'b1;
        if (wrap) begin
          job.bytes[1] = INS_ROW1;
          job.count    = bus_mode ? 3'd4 : 3'd2;
        end else begin
          job.count    = bus_mode ? 3'd2 : 3'd1;
        end
      end
      CMD_CURSOR: begin
        job.bytes[0] = INS_ROW0 + {2'b00, item.column} + {1'b0, item.row, 6'b0};
        job.count    = bus_mode ? 3'd2 : 3'd1;
      end
      CMD_CLEAR: begin
        job.bytes[0] = INS_CLEAR;
        job.count    = bus_mode ? 3'd2 : 3'd1;
      end
      CMD_INIT: begin
        job.wait_first = startup_ticks != '0;
        if (bus_mode) begin
          job.bytes[0] = INS_FUNC_4BIT;
          job.bytes[1] = INS_ROW0;
          job.bytes[2] = INS_ROW1;
          job.bytes[3] = INS_ENTRY_LAST;
          job.count    = 3'd7;
        end else begin
          job.bytes[0] = INS_FUNC_8BIT;
          job.bytes[1] = INS_DISP_ON;
          job.bytes[2] = INS_CLEAR;
          job.count    = 3'd3;
        end
      end
      default: known = 1'b0;
    endcase

    q_wr.push = accept && known;
    q_wr.job  = job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_column <= '0;
    end else if (accept && item.cmd == CMD_DATA) begin
      text_column <= text_column_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/clb_queue.sv
// Two-entry job queue between the front and back ends.
`default_nettype none
module clb_queue import clb_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire q_wr_t q_wr,
  input  wire logic  pop,
  output logic       full,
  output q_rd_t      q_rd
);

  job_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] fill;
  logic               do_pop;

  assign full       = fill == Q_CNT_W'(Q_DEPTH);
  assign q_rd.valid = fill != '0;
  assign q_rd.job   = entries[rd_ptr];
  assign do_pop     = pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (q_wr.push && !full) begin
      entries[wr_ptr] <= q_wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (q_wr.push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + Q_CNT_W'(q_wr.push && !full) - Q_CNT_W'(do_pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_wr.push |-> !full) else $error("job pushed into a full queue");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= Q_CNT_W'(Q_DEPTH)) else $error("queue fill count out of range");

endmodule
`default_nettype wire

// File: rtl/core/clb_back.sv
// Back end: expands queued jobs into bus transfers, one per cycle while the output is not stalled.
`default_nettype none
module clb_back import clb_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire q_rd_t q_rd,
  output logic       pop,
  clb_out_if.source  xfer
);

  logic [CNT_W-1:0]  idx;
  logic [BSEL_W-1:0] bsel;
  logic [7:0]        cur_byte;
  logic [7:0]        value;
  logic              is_last;
  logic              advance;
  logic              take;
  logic              out_mode;

  always_comb begin
    advance  = !xfer.valid || xfer.ready;
    take     = advance && q_rd.valid;
    bsel     = q_rd.job.mode ? idx[2:1] : idx[1:0];
    cur_byte = q_rd.job.bytes[bsel];
    if (!q_rd.job.mode) begin
      value = cur_byte;
    end else if (idx[0]) begin
      value = {cur_byte[3:0], 4'h0};
    end else begin
      value = {cur_byte[7:4], 4'h0};
    end
    is_last = idx == (q_rd.job.count - 3'd1);
    pop     = take && is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xfer.valid <= 1'b0;
      idx        <= '0;
    end else if (advance) begin
      xfer.valid <= q_rd.valid;
      if (take) begin
        idx <= is_last ? '0 : idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      xfer.reg_select   <= q_rd.job.rs[bsel];
      xfer.bus_value    <= value;
      xfer.startup_wait <= q_rd.job.wait_first && idx == '0;
      xfer.last         <= is_last;
      out_mode          <= q_rd.job.mode;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    q_rd.valid |-> idx < q_rd.job.count) else $error("transfer index beyond job");
  a_idx_restart: assert property (@(posedge clk) disable iff (rst)
    pop |=> idx == '0) else $error("transfer index not cleared after job");
  a_nibble_low_zero: assert property (@(posedge clk) disable iff (rst)
    (xfer.valid && out_mode) |-> xfer.bus_value[3:0] == 4'h0)
    else $error("nibble transfer has low bits set");

endmodule
`default_nettype wire

// File: sim/char_lcd_bus_sequencer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the character-LCD bus sequencer core.
module char_lcd_bus_sequencer_core_tb;
  import clb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic [7:0] ROW_STEP = 8'h40;
  localparam logic [CFG_DATA_W-1:0] TICKS_MAX = 22'h3FFFFF;
  localparam logic [5:0] WRAP_MAX = 6'd40;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [7:0]       byte_value;
    logic [COL_W-1:0] column;
    logic             row;
    logic             text_start;
  } lcd_req_t;

  typedef struct packed {
    logic       reg_select;
    logic [7:0] bus_value;
    logic       startup_wait;
    logic       last;
  } bus_xfer_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit sink_ready;
  int unsigned ready_run;
  int unsigned cycle_count;

  logic mode_4bit;
  logic [21:0] startup_len;
  logic [5:0] wrap_len;
  logic [5:0] char_count;
  bus_xfer_t pending_xfers[$];
  int fail_count;
  int items_sent;
  int xfers_checked;
  int wraps_seen;
  bit valid_held;
  int burst_left;

  clb_in_if item_ch();
  clb_out_if xfer_ch();
  assign xfer_ch.ready = sink_ready;

  char_lcd_bus_sequencer_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item(item_ch),
    .xfer(xfer_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else if (sink_ready && cycle_count[9:8] != 2'b11) begin
      sink_ready <= 1'b0;
      ready_run <= $urandom_range(0, 5);
    end else begin
      sink_ready <= 1'b1;
      ready_run <= $urandom_range(0, 12);
    end
  end

  always @(posedge clk) begin
    bus_xfer_t got;
    bus_xfer_t want;
    if (!rst && xfer_ch.valid === 1'b1 && sink_ready) begin
      got = {xfer_ch.reg_select, xfer_ch.bus_value, xfer_ch.startup_wait, xfer_ch.last};
      if (pending_xfers.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected transfer rs=%0d bus=%02h sw=%0d last=%0d",
                   $time, got.reg_select, got.bus_value, got.startup_wait, got.last);
      end else begin
        want = pending_xfers.pop_front();
        xfers_checked++;
        if (got.reg_select !== want.reg_select || got.bus_value !== want.bus_value ||
            got.startup_wait !== want.startup_wait || got.last !== want.last) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: expected rs=%0d bus=%02h sw=%0d last=%0d, got rs=%0d bus=%02h sw=%0d last=%0d",
                     $time, want.reg_select, want.bus_value, want.startup_wait, want.last,
                     got.reg_select, got.bus_value, got.startup_wait, got.last);
        end
      end
    end
  end

  function automatic lcd_req_t mk_req(logic [CMD_W-1:0] cmd, logic [7:0] b,
                                      logic [COL_W-1:0] col, logic row, logic ts);
    lcd_req_t r;
    r.cmd = cmd;
    r.byte_value = b;
    r.column = col;
    r.row = row;
    r.text_start = ts;
    return r;
  endfunction

  function automatic bus_xfer_t mk_xfer(logic rs, logic [7:0] v, logic sw, logic l);
    bus_xfer_t x;
    x.reg_select = rs;
    x.bus_value = v;
    x.startup_wait = sw;
    x.last = l;
    return x;
  endfunction

  // Expands one request into the bus transfers it should produce.
  function automatic void expand_request(input lcd_req_t r);
    logic [7:0] seq [0:3];
    logic [3:0] rs_of;
    int n;
    logic startup_flag;
    logic high_only;
    logic is_end;
    n = 0;
    startup_flag = 1'b0;
    high_only = 1'b0;
    rs_of = '0;
    case (r.cmd)
      CMD_COMMAND: begin
        seq[0] = r.byte_value;
        n = 1;
      end
      CMD_DATA: begin
        if (r.text_start) char_count = '0;
        seq[0] = r.byte_value;
        rs_of[0] = 1'b1;
        n = 1;
        if (char_count < COL_MAX) begin
          char_count = char_count + 1'b1;
          if (char_count == wrap_len) begin
            seq[1] = INS_ROW1;
            n = 2;
            wraps_seen++;
          end
        end
      end
      CMD_CURSOR: begin
        seq[0] = INS_ROW0 + {2'b00, r.column} + (r.row ? ROW_STEP : 8'h00);
        n = 1;
      end
      CMD_CLEAR: begin
        seq[0] = INS_CLEAR;
        n = 1;
      end
      CMD_INIT: begin
        startup_flag = (startup_len != '0);
        if (!mode_4bit) begin
          seq[0] = INS_FUNC_8BIT;
          seq[1] = INS_DISP_ON;
          seq[2] = INS_CLEAR;
          n = 3;
        end else begin
          seq[0] = INS_FUNC_4BIT;
          seq[1] = INS_ROW0;
          seq[2] = INS_ROW1;
          seq[3] = INS_ENTRY_LAST;
          n = 4;
          high_only = 1'b1;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      is_end = (i == n - 1);
      if (!mode_4bit) begin
        pending_xfers.push_back(mk_xfer(rs_of[i], seq[i], (i == 0) && startup_flag, is_end));
      end else begin
        pending_xfers.push_back(mk_xfer(rs_of[i], {seq[i][7:4], 4'h0},
                                        (i == 0) && startup_flag, is_end && high_only));
        if (!(is_end && high_only))
          pending_xfers.push_back(mk_xfer(rs_of[i], {seq[i][3:0], 4'h0}, 1'b0, is_end));
      end
    end
  endfunction

  task automatic send_item(input lcd_req_t r);
    int gap;
    if (!valid_held) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    item_ch.valid <= 1'b1;
    item_ch.cmd <= r.cmd;
    item_ch.byte_value <= r.byte_value;
    item_ch.column <= r.column;
    item_ch.row <= r.row;
    item_ch.text_start <= r.text_start;
    valid_held = 1'b1;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    expand_request(r);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      item_ch.valid <= 1'b0;
      valid_held = 1'b0;
    end
  endtask

  task automatic send_text(input int len, input logic start);
    for (int i = 0; i < len; i++)
      send_item(mk_req(CMD_DATA, 8'($urandom_range(0, 255)), COL_W'($urandom_range(0, 63)),
                       1'($urandom_range(0, 1)), start && (i == 0)));
  endtask

  task automatic wait_drained();
    if (valid_held) begin
      item_ch.valid <= 1'b0;
      valid_held = 1'b0;
    end
    while (pending_xfers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BUS_MODE: mode_4bit = data[0];
      REG_STARTUP_TICKS: startup_len = data[21:0];
      REG_ROW_LENGTH: wrap_len = data[5:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic mode, input logic [21:0] pulse,
                               input logic [21:0] startup, input logic [5:0] rowlen);
    wait_drained();
    write_cfg(REG_BUS_MODE, {21'd0, mode});
    write_cfg(REG_PULSE_TICKS, pulse);
    write_cfg(REG_STARTUP_TICKS, startup);
    write_cfg(REG_ROW_LENGTH, {16'd0, rowlen});
  endtask

  task automatic test_reset_defaults();
    send_item(mk_req(CMD_INIT, 8'h00, '0, 1'b0, 1'b0));
    send_item(mk_req(CMD_DATA, 8'h41, '0, 1'b0, 1'b1));
    send_item(mk_req(CMD_COMMAND, 8'h28, '0, 1'b0, 1'b0));
    wait_drained();
  endtask

  task automatic test_directed_8bit();
    apply_setting(1'b0, 22'd1, 22'd0, WRAP_MAX);
    send_item(mk_req(CMD_COMMAND, 8'h00, '0, 1'b0, 1'b0));
    send_item(mk_req(CMD_COMMAND, 8'hFF, '0, 1'b0, 1'b0));
    send_item(mk_req(CMD_COMMAND, INS_ENTRY_LAST, '0, 1'b0, 1'b0));
    send_item(mk_req(CMD_DATA, 8'h00, '0, 1'b0, 1'b1));
    send_item(mk_req(CMD_DATA, 8'hFF, 6'd63, 1'b1, 1'b0));
    send_item(mk_req(CMD_CURSOR, 8'h00, 6'd0, 1'b0, 1'b0));
    send_item(mk_req(CMD_CURSOR, 8'h00, 6'd39, 1'b1, 1'b0));
    send_item(mk_req(CMD_CURSOR, 8'hFF, 6'd63, 1'b1, 1'b1));
    send_item(mk_req(CMD_CLEAR, 8'h00, '0, 1'b0, 1'b0));
    send_item(mk_req(CMD_INIT, 8'h00, '0, 1'b0, 1'b0));
    send_item(mk_req(CMD_SPARE_FIRST, 8'hFF, 6'd63, 1'b1, 1'b1));
    send_item(mk_req(CMD_SPARE_LAST, 8'h00, '0, 1'b0, 1'b0));
    wait_drained();
  endtask

  task automatic test_directed_4bit();
    apply_setting(1'b1, TICKS_MAX, TICKS_MAX, 6'd1);
    send_item(mk_req(CMD_COMMAND, INS_ENTRY_LAST, '0, 1'b0, 1'b0));
    send_item(mk_req(CMD_COMMAND, 8'hA5, '0, 1'b0, 1'b0));
    send_item(mk_req(CMD_DATA, 8'h5A, '0, 1'b0, 1'b1));
    send_item(mk_req(CMD_DATA, 8'hC3, '0, 1'b0, 1'b0));
    send_item(mk_req(CMD_CURSOR, 8'h00, 6'd63, 1'b1, 1'b0));
    send_item(mk_req(CMD_CLEAR, 8'h00, '0, 1'b0, 1'b0));
    send_item(mk_req(CMD_INIT, 8'h00, '0, 1'b0, 1'b0));
    send_item(mk_req(CMD_SPARE_FIRST + 1'b1, 8'h3C, 6'd21, 1'b0, 1'b1));
    wait_drained();
  endtask

  task automatic test_text_wrap();
    apply_setting(1'b1, 22'd100000, 22'd0, 6'd16);
    send_text(20, 1'b1);
    send_text(10, 1'b1);
    send_item(mk_req(CMD_CLEAR, 8'h00, '0, 1'b0, 1'b0));
    send_text(8, 1'b0);
    apply_setting(1'b0, 22'd5, 22'd7, 6'd1);
    send_text(3, 1'b1);
    send_text(2, 1'b1);
    apply_setting(1'b0, 22'd5, 22'd7, WRAP_MAX);
    send_text(42, 1'b1);
    wait_drained();
  endtask

  task automatic test_counter_saturation();
    apply_setting(1'b0, 22'd1, 22'd1, 6'd0);
    send_text(5, 1'b1);
    apply_setting(1'b1, 22'd1, 22'd1, COL_MAX);
    send_text(65, 1'b1);
    send_text(3, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int counted;
    int pick;
    int len;
    bit paused;
    paused = 1'b0;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: apply_setting(1'b0, 22'd1, 22'd0, 6'd1);
        1: apply_setting(1'b1, TICKS_MAX, TICKS_MAX, WRAP_MAX);
        2: apply_setting(1'b0, 22'($urandom_range(1, TICKS_MAX)),
                         22'($urandom_range(0, TICKS_MAX)), 6'($urandom_range(1, WRAP_MAX)));
        3: apply_setting(1'b1, 22'($urandom_range(1, TICKS_MAX)),
                         22'($urandom_range(0, TICKS_MAX)), 6'($urandom_range(1, 8)));
        default: apply_setting(1'($urandom_range(0, 1)), 22'($urandom_range(1, TICKS_MAX)),
                               $urandom_range(0, 1) ? 22'd0 : TICKS_MAX,
                               6'($urandom_range(1, WRAP_MAX)));
      endcase
      counted = 0;
      while (counted < 12) begin
        if (p == 2 && counted >= 6 && !paused) begin
          wait_drained();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, wrap_len + 4)
                                            : $urandom_range(1, 20);
          send_text(len, 1'b1);
          counted += len;
        end else if (pick < 55) begin
          send_item(mk_req(CMD_COMMAND, 8'($urandom_range(0, 255)),
                           COL_W'($urandom_range(0, 63)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
          counted++;
        end else if (pick < 70) begin
          send_item(mk_req(CMD_CURSOR, 8'($urandom_range(0, 255)),
                           COL_W'($urandom_range(0, 63)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
          counted++;
        end else if (pick < 80) begin
          send_item(mk_req(CMD_CLEAR, 8'($urandom_range(0, 255)),
                           COL_W'($urandom_range(0, 63)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
          counted++;
        end else if (pick < 90) begin
          send_item(mk_req(CMD_INIT, 8'($urandom_range(0, 255)),
                           COL_W'($urandom_range(0, 63)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
          counted++;
        end else if (pick < 95) begin
          send_item(mk_req(CMD_DATA, 8'($urandom_range(0, 255)),
                           COL_W'($urandom_range(0, 63)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
          counted++;
        end else begin
          send_item(mk_req(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                           8'($urandom_range(0, 255)), COL_W'($urandom_range(0, 63)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_BUS_MODE;
    cfg_data <= '0;
    item_ch.valid <= 1'b0;
    item_ch.cmd <= CMD_COMMAND;
    item_ch.byte_value <= '0;
    item_ch.column <= '0;
    item_ch.row <= 1'b0;
    item_ch.text_start <= 1'b0;
    mode_4bit = RST_BUS_MODE;
    startup_len = RST_STARTUP_TICKS;
    wrap_len = RST_ROW_LENGTH;
    char_count = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_8bit();
    test_directed_4bit();
    test_text_wrap();
    test_counter_saturation();
    test_random_traffic();
    wait_drained();
    $display("Sent %0d requests and checked %0d bus transfers, %0d of them row wraps.",
             items_sent, xfers_checked, wraps_seen);
    $display("Both bus widths, init with and without power-up wait, and counter saturation ran.");
    if (fail_count == 0) begin
      $display("char_lcd_bus_sequencer_core verification clean");
    end else begin
      $display("char_lcd_bus_sequencer_core verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("char_lcd_bus_sequencer_core verification failed");
    $finish;
  end

endmodule
